/* hdl/indexed_insert_remove_list_core_defines.svh */
// Assertion macros for the indexed insert/remove list.
// Used by the port checker; no other dependencies.
`ifndef INDEXED_INSERT_REMOVE_LIST_CORE_DEFINES_SVH
`define INDEXED_INSERT_REMOVE_LIST_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IIRL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iirl check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define IIRL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iirl check failed");

`endif

/* hdl/iirl_pkg.sv */
// Shared types and constants for the indexed insert/remove list.
// No dependencies.
`default_nettype none

package iirl_pkg;

    localparam int POS_W          = 5;
    localparam int LEN_W          = 5;
    localparam int OUT_DATA_W     = 32;
    localparam int IN_DATA_W      = 32;
    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [POS_W-1:0] pos;
    } iirl_cmd_t;

endpackage

`default_nettype wire

/* hdl/indexed_insert_remove_list_core.sv */
// Indexed insert/remove list: a chain of word cells plus length control.
// Depends on iirl_pkg and iirl_cell.
// Usage:
//   Input channel (in_valid / in_stall): one item per command. mode 0
//   inserts data_in before position (0 is the head); mode 1 removes the
//   word at position. An item is taken at a clock edge with in_valid high
//   and in_stall low.
//   Output channel (out_valid / out_stall): one result item per command,
//   with status (ok, range/empty error, full), data_out (removed word on a
//   good removal, else 0) and length (word count after the command).
// Timing:
//   All cells shift toward or away from their neighbor in the same clock, so
//   the result is registered at acceptance and a new item can be taken
//   every cycle while the output is not stalled.
// Stall:
//   The result sits in the output register until taken; in_stall rises
//   only while that register is full and out_stall is high.
// Reset:
//   rst_n clears the word count and the output valid. Cell contents are not
//   reset; only cells below the length are ever read.
`default_nettype none

module indexed_insert_remove_list_core
    import iirl_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  mode,
    input  wire logic [POS_W-1:0]      position,
    input  wire logic [IN_DATA_W-1:0]  data_in,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [1:0]            status,
    output logic      [OUT_DATA_W-1:0] data_out,
    output logic      [LEN_W-1:0]      length
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // control state
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;

    // result payload
    status_t               status_reg, status_next;
    logic [OUT_DATA_W-1:0] data_out_reg, data_out_next;
    logic [LEN_W-1:0]      length_reg, length_next;

    logic                  in_accept;
    logic [CMP_W-1:0]      pos_w, cnt_w;
    logic                  ins_pos_ok, rem_pos_ok, full;
    logic                  do_ins, do_rem;
    iirl_cmd_t             cmd;
    logic [DATA_WIDTH-1:0] word_in;
    logic [DATA_WIDTH-1:0] taken;

    logic [DATA_WIDTH-1:0] words [CAPACITY];
    logic [DATA_WIDTH-1:0] taps  [CAPACITY];

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign pos_w   = CMP_W'(position);
    assign cnt_w   = CMP_W'(count_reg);
    assign word_in = DATA_WIDTH'(data_in);

    // insert on an empty list only at the head; otherwise below the length
    assign ins_pos_ok = (count_reg == '0) ? (position == '0) : (pos_w < cnt_w);
    assign rem_pos_ok = pos_w < cnt_w;
    assign full       = count_reg == CAP_CNT;

    assign do_ins = in_accept && !mode && ins_pos_ok && !full;
    assign do_rem = in_accept && mode && rem_pos_ok;

    assign cmd.ins = do_ins;
    assign cmd.rem = do_rem;
    assign cmd.pos = position;

    // cell chain
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] prev_w, next_w;

        if (g == 0)
        begin : g_head
            assign prev_w = word_in;
        end
        else
        begin : g_mid_prev
            assign prev_w = words[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_tail
            assign next_w = words[g];
        end
        else
        begin : g_mid_next
            assign next_w = words[g+1];
        end

        iirl_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CMP_W      (CMP_W),
            .INDEX      (g)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .din       (word_in),
            .prev_word (prev_w),
            .next_word (next_w),
            .word      (words[g]),
            .tap       (taps[g])
        );
    end

    // only the cell at position drives a nonzero tap
    always_comb
    begin
        taken = '0;
        for (int i = 0; i < CAPACITY; i++)
            taken = taken | taps[i];
    end

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        data_out_next  = data_out_reg;
        length_next    = length_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (in_accept)
        begin
            out_valid_next = 1'b1;
            data_out_next  = '0;
            priority if (do_ins)
            begin
                count_next  = count_reg + 1'b1;
                status_next = ST_OK;
            end
            else if (do_rem)
            begin
                count_next    = count_reg - 1'b1;
                status_next   = ST_OK;
                data_out_next = OUT_DATA_W'(taken);
            end
            else if (!mode && ins_pos_ok)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_RANGE;
            end
            length_next = LEN_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        data_out_reg <= data_out_next;
        length_reg   <= length_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data_out  = data_out_reg;
    assign length    = length_reg;

endmodule

`default_nettype wire

/* hdl/iirl_cell.sv */
// One storage cell of the list chain.
// Depends on iirl_pkg (iirl_cmd_t).
`default_nettype none

module iirl_cell
    import iirl_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int CMP_W      = POS_W,
    parameter int INDEX      = 0
)
(
    input  wire logic                  clk,
    input  wire iirl_cmd_t             cmd,
    input  wire logic [DATA_WIDTH-1:0] din,
    input  wire logic [DATA_WIDTH-1:0] prev_word,
    input  wire logic [DATA_WIDTH-1:0] next_word,
    output logic      [DATA_WIDTH-1:0] word,
    output logic      [DATA_WIDTH-1:0] tap
);

    localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

    logic [DATA_WIDTH-1:0] word_reg;
    logic [CMP_W-1:0]      pos_w;

    assign pos_w = CMP_W'(cmd.pos);

    // insert: above pos take lower neighbor, at pos load; remove: at/above pos take upper
    always_ff @(posedge clk)
    begin
        if (cmd.ins)
        begin
            if (IDX > pos_w)
                word_reg <= prev_word;
            else if (IDX == pos_w)
                word_reg <= din;
        end
        else if (cmd.rem && (IDX >= pos_w))
        begin
            word_reg <= next_word;
        end
    end

    assign word = word_reg;
    assign tap  = (IDX == pos_w) ? word_reg : '0;

endmodule

`default_nettype wire

/* hdl/iirl_checker.sv */
// Port-level checks for the indexed insert/remove list, bound to the top.
// Depends on iirl_pkg and indexed_insert_remove_list_core_defines.svh.
`default_nettype none

`include "indexed_insert_remove_list_core_defines.svh"

module iirl_checker
    import iirl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_stall,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [1:0]            status,
    input wire logic [OUT_DATA_W-1:0] data_out,
    input wire logic [LEN_W-1:0]      length
);

    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    // held result must not change
    `IIRL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(data_out) && $stable(length))

    // input backs up only behind a waiting result
    `IIRL_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

    // failed commands return no data
    `IIRL_ASSERT_NOW(a_err_data_zero, out_valid && (status != ST_OK), data_out == '0)

    // full status reports the list at capacity
    `IIRL_ASSERT_NOW(a_full_len, out_valid && (status == ST_FULL), length == CAP_LEN)

endmodule

bind indexed_insert_remove_list_core iirl_checker #(
    .CAPACITY (CAPACITY)
) u_iirl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .data_out  (data_out),
    .length    (length)
);

`default_nettype wire

/* dv/tb.sv */
// Testbench for indexed_insert_remove_list_core: queued stimulus, a clocked driver and monitor,
// and a scoreboard fed by a built-in list predictor. Depends on iirl_pkg and the core RTL.
`default_nettype none

module tb;
    import iirl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Run bounds. Slowest phases idle the sender or stall the receiver 74% of the
    // time; the cycle limit leaves ample room for a couple of thousand items.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_SLACK   = 8;
    localparam int PHASE_ITEMS   = 440;
    localparam int CAPACITY      = CAPACITY_DEF;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef struct {
        logic                  op;
        logic [POS_W-1:0]      pos;
        logic [IN_DATA_W-1:0]  word;
    } list_cmd_t;

    typedef struct {
        status_t               st;
        logic [OUT_DATA_W-1:0] word;
        logic [LEN_W-1:0]      len;
    } list_result_t;

    // ---------------------------------------------------------------------------------
    // DUT hookup. Every input has a known value from time zero.
    // ---------------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic                  mode      = 1'b0;
    logic [POS_W-1:0]      position  = '0;
    logic [IN_DATA_W-1:0]  data_in   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [1:0]            status;
    logic [OUT_DATA_W-1:0] data_out;
    logic [LEN_W-1:0]      length;

    indexed_insert_remove_list_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .position  (position),
        .data_in   (data_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data_out  (data_out),
        .length    (length)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------------------------
    // Shared testbench state
    // ---------------------------------------------------------------------------------
    list_cmd_t     pending_cmds[$];      // items waiting for the driver
    list_result_t  expected_results[$];  // predictions waiting for the DUT
    int unsigned   error_count   = 0;
    int unsigned   cycle_count   = 0;
    int unsigned   send_idle_pct = 0;    // chance per cycle that the sender holds off
    int unsigned   recv_stall_pct = 0;   // chance per cycle that the receiver stalls
    bit            cmd_taken     = 1'b0; // set at the edge that accepted the shown item
    list_cmd_t     next_cmd;

    // Predictor state: the list contents, head at index 0, and its length.
    logic [DATA_WIDTH_DEF-1:0] shadow_cells[CAPACITY];
    logic [LEN_W-1:0]          shadow_len = '0;

    // Length as the stimulus generator expects it; used only to aim positions.
    int planned_len = 0;

    // ---------------------------------------------------------------------------------
    // Predictor: applies one command to the shadow list and returns its result item.
    // Range is checked before fullness, so an out-of-range insert on a full list is a
    // range error. Removal shifts the tail toward the head.
    // ---------------------------------------------------------------------------------
    function automatic list_result_t list_apply(input list_cmd_t cmd);
        list_result_t res;
        bit           pos_ok;
        res.st   = ST_OK;
        res.word = '0;
        if (cmd.op == MODE_INSERT) begin
            pos_ok = (shadow_len == 0) ? (cmd.pos == 0) : (cmd.pos < shadow_len);
            if (!pos_ok) begin
                res.st = ST_RANGE;
            end
            else if (shadow_len >= CAPACITY) begin
                res.st = ST_FULL;
            end
            else begin
                for (int i = int'(shadow_len); i > int'(cmd.pos); i--)
                    shadow_cells[i] = shadow_cells[i-1];
                shadow_cells[cmd.pos] = cmd.word[DATA_WIDTH_DEF-1:0];
                shadow_len = shadow_len + 1'b1;
            end
        end
        else begin
            if (shadow_len == 0 || cmd.pos >= shadow_len) begin
                res.st = ST_RANGE;
            end
            else begin
                res.word = shadow_cells[cmd.pos];
                for (int i = int'(cmd.pos); i + 1 < int'(shadow_len); i++)
                    shadow_cells[i] = shadow_cells[i+1];
                shadow_len = shadow_len - 1'b1;
            end
        end
        res.len = shadow_len;
        return res;
    endfunction

    // Queue one command and track where the list length will land.
    task automatic queue_cmd(input logic op, input int pos, input logic [IN_DATA_W-1:0] word);
        list_cmd_t cmd;
        bit        pos_ok;
        cmd.op   = op;
        cmd.pos  = pos[POS_W-1:0];
        cmd.word = word;
        pending_cmds.push_back(cmd);
        if (op == MODE_INSERT) begin
            pos_ok = (planned_len == 0) ? (pos == 0) : (pos < planned_len);
            if (pos_ok && planned_len < CAPACITY)
                planned_len++;
        end
        else if (pos < planned_len) begin
            planned_len--;
        end
    endtask

    function automatic logic [IN_DATA_W-1:0] pick_word();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return '0;
        else if (roll < 20)
            return '1;
        return $urandom;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
            error_count++;
        end
    endfunction

    // ---------------------------------------------------------------------------------
    // Driver: inputs move on the falling edge only. A shown item is held until the
    // rising edge that accepts it; the decision to show a new one never looks at stall.
    // ---------------------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || cmd_taken) begin
                cmd_taken = 1'b0;
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_cmd = pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    mode     <= next_cmd.op;
                    position <= next_cmd.pos;
                    data_in  <= next_cmd.word;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Acceptance: predict at the edge the item goes in.
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            expected_results.push_back(list_apply('{op: mode, pos: position, word: data_in}));
            cmd_taken = 1'b1;
        end
    end

    // ---------------------------------------------------------------------------------
    // Monitor: every result taken is matched against the oldest prediction.
    // ---------------------------------------------------------------------------------
    always @(posedge clk) begin
        list_result_t exp_res;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result item with no prediction: status %0h data_out %0h length %0h",
                       status, data_out, length);
                error_count++;
            end
            else begin
                exp_res = expected_results.pop_front();
                check_field("status", 32'(exp_res.st), 32'(status));
                check_field("data_out", exp_res.word, data_out);
                check_field("length", 32'(exp_res.len), 32'(length));
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("indexed_insert_remove_list_core regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------------------------
    initial begin
        bit          filling;
        int unsigned roll;
        int          pos;
        logic        op;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty-list errors, fill to capacity, full and range errors, removals
        // at tail, head and middle.
        queue_cmd(MODE_REMOVE, 0, pick_word());         // remove from empty list
        queue_cmd(MODE_REMOVE, 31, '1);                 // all position bits set, empty
        queue_cmd(MODE_INSERT, 1, 32'h1234_5678);       // nonzero insert on empty list
        queue_cmd(MODE_INSERT, 31, '1);
        queue_cmd(MODE_INSERT, 0, '0);                  // first word, all zero
        queue_cmd(MODE_INSERT, 0, '1);                  // head insert, all ones
        for (int i = 2; i < CAPACITY; i++)
            queue_cmd(MODE_INSERT, (i * 7) % planned_len, $urandom);
        queue_cmd(MODE_INSERT, 0, $urandom);            // full list
        queue_cmd(MODE_INSERT, CAPACITY, $urandom);     // out of range beats full
        queue_cmd(MODE_INSERT, CAPACITY - 1, '1);       // last valid position, full
        queue_cmd(MODE_REMOVE, CAPACITY, $urandom);     // out of range remove
        queue_cmd(MODE_REMOVE, CAPACITY - 1, $urandom); // tail
        queue_cmd(MODE_REMOVE, 0, $urandom);            // head
        queue_cmd(MODE_REMOVE, 7, $urandom);            // middle

        // Random phases with different idle/stall mixes. Most items are in range so the
        // list sweeps between empty and full; the rest are noise with any position.
        filling = 1'b1;
        for (int phase = 0; phase < 4; phase++) begin
            // Sender holds off until everything outstanding has come back.
            while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
                @(posedge clk);
            repeat (3) @(posedge clk);

            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (planned_len == CAPACITY)
                    filling = 1'b0;
                else if (planned_len == 0)
                    filling = 1'b1;
                else if ($urandom_range(99) < 4)
                    filling = ~filling;

                roll = $urandom_range(99);
                if (roll < 15) begin
                    op  = 1'($urandom);
                    pos = $urandom_range(31);
                end
                else begin
                    op = ($urandom_range(99) < (filling ? 75 : 25)) ? MODE_INSERT
                                                                     : MODE_REMOVE;
                    pos = (planned_len == 0) ? 0 : $urandom_range(planned_len - 1);
                end
                queue_cmd(op, pos, pick_word());
            end
        end

        // Drain, then wait out the drain slack so anything extra can show.
        while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);

        if (expected_results.size() != 0) begin
            $error("%0d predicted results never arrived", expected_results.size());
            error_count++;
        end

        if (error_count == 0)
            $display("indexed_insert_remove_list_core regression: pass");
        else
            $display("indexed_insert_remove_list_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
